// ----- rtl/core/bch_pkg.sv -----
`default_nettype none
package bch_pkg;

  localparam int unsigned GfN     = 63;
  localparam int unsigned NumSyn  = 22;
  localparam int unsigned TMax    = 11;
  localparam int unsigned LocLen  = 24;
  localparam int unsigned NacBits = 12;

  typedef logic [5:0] gf_t;

  // alpha^i for i in 0..62, with x^6+x^5+1
  function automatic gf_t gf_exp(input logic [5:0] idx);
    logic [6:0] r;
    r = 7'd1;
    for (int k = 0; k < 63; k++) begin
      if (k[5:0] == idx) begin
        return r[5:0];
      end
      r = {r[5:0], 1'b0};
      if (r[6]) begin
        r = r ^ 7'h61;
      end
    end
    return 6'd1;
  endfunction

  function automatic logic [5:0] gf_log(input gf_t v);
    logic [6:0] r;
    r = 7'd1;
    for (int k = 0; k < 63; k++) begin
      if (r[5:0] == v) begin
        return k[5:0];
      end
      r = {r[5:0], 1'b0};
      if (r[6]) begin
        r = r ^ 7'h61;
      end
    end
    return 6'd0;
  endfunction

  // exponent sum modulo 63
  function automatic logic [5:0] mod63_add(input logic [5:0] a, input logic [5:0] b);
    logic [6:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 7'd63) begin
      s = s - 7'd63;
    end
    return s[5:0];
  endfunction

  // shared multiplier: one log/antilog product
  function automatic gf_t gf_mul(input gf_t a, input gf_t b);
    if (a == 6'd0 || b == 6'd0) begin
      return 6'd0;
    end
    return gf_exp(mod63_add(gf_log(a), gf_log(b)));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/bch_gf_mac.sv -----
`default_nettype none
module bch_gf_mac (
  input  wire bch_pkg::gf_t a_i,
  input  wire bch_pkg::gf_t b_i,
  input  wire bch_pkg::gf_t acc_i,
  output bch_pkg::gf_t      y_o
);
  import bch_pkg::*;
  // shared gf(64) multiply-accumulate
  assign y_o = acc_i ^ gf_mul(a_i, b_i);
endmodule
`default_nettype wire

// ----- rtl/core/bch_63_16_nid_decoder_core.sv -----
`default_nettype none
// bch(63,16,11) nid decoder, one shared gf(64) multiply-accumulate under a sequencer
// steps: syndromes, then berlekamp-massey locator, then chien search over every bit
//   position; an all-zero syndrome set skips the locator and chien steps
// throughput: one item at a time; s_axis_tready is low while an item is in work
// the result sits in an output register until taken
// reset: asynchronous active low; clears the sequencer and output valid
module bch_63_16_nid_decoder_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,   // codeword[62:0]
  input  wire         m_axis_tready,
  output logic        m_axis_tvalid,
  output logic [23:0] m_axis_tdata    // decoded_ok, error_count[3:0], nac[11:0], duid[3:0]
);
  import bch_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SYN, ST_BM_D, ST_BM_UPD, ST_BM_NEXT, ST_CH, ST_CH_NEXT, ST_DONE, ST_OUT
  } state_e;

  state_e      state_q;
  logic [62:0] word_q;
  gf_t         syn_q [NumSyn+1];
  gf_t         c_q [LocLen];
  gf_t         b_q [LocLen];
  gf_t         t_q [LocLen];
  logic [4:0]  len_q;       // locator degree
  logic [4:0]  m_q;
  gf_t         bd_q;        // previous discrepancy
  gf_t         d_q;         // running discrepancy / chien sum
  gf_t         coef_q;
  logic [4:0]  n_q;         // bm step / syndrome index
  logic [5:0]  j_q;         // bit position / chien index
  logic [4:0]  i_q;         // coefficient index
  logic        nz_q;
  logic [62:0] flips_q;
  logic [3:0]  cnt_q;
  logic        grow_q;

  // shared unit operands
  gf_t mac_a, mac_b, mac_acc, mac_y;
  bch_gf_mac u_mac (.a_i(mac_a), .b_i(mac_b), .acc_i(mac_acc), .y_o(mac_y));

  logic [10:0] ij_prod;
  logic [5:0]  ij_mod;
  always_comb begin
    mac_a   = 6'd0;
    mac_b   = 6'd0;
    mac_acc = d_q;
    ij_prod = 11'd0;
    ij_mod  = 6'd0;
    case (state_q)
      ST_SYN: begin
        // alpha^(i*j): i*j mod 63 by a small fold (values below 63*22)
        ij_prod = {6'd0, n_q} * {5'd0, j_q};
        ij_mod  = mod63_add(ij_prod[5:0], {1'b0, ij_prod[10:6]});
        mac_a   = word_q[j_q] ? gf_exp(ij_mod) : 6'd0;
        mac_b   = 6'd1;
      end
      ST_BM_D: begin
        mac_a = c_q[i_q];
        mac_b = syn_q[n_q + 5'd1 - i_q];
      end
      ST_BM_UPD: begin
        mac_a   = coef_q;
        mac_b   = b_q[i_q];
        mac_acc = c_q[i_q + m_q];
      end
      ST_CH: begin
        ij_prod = {6'd0, i_q} * {5'd0, j_q};
        ij_mod  = mod63_add(ij_prod[5:0], {1'b0, ij_prod[10:6]});
        mac_a   = c_q[i_q];
        mac_b   = gf_exp(ij_mod);
      end
      default: ;
    endcase
  end

  logic [5:0] pos;
  assign pos = (j_q == 6'd0) ? 6'd0 : 6'd63 - j_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            word_q   <= s_axis_tdata[62:0];
            syn_q[0] <= 6'd0;
            n_q      <= 5'd1;
            j_q      <= 6'd0;
            d_q      <= 6'd0;
            nz_q     <= 1'b0;
            state_q  <= ST_SYN;
          end
        end
        ST_SYN: begin
          if (j_q == 6'd62) begin
            syn_q[n_q] <= mac_y;
            d_q        <= 6'd0;
            j_q        <= 6'd0;
            if (mac_y != 6'd0) nz_q <= 1'b1;
            if (n_q == 5'(NumSyn)) begin
              if (!nz_q && mac_y == 6'd0) begin
                cnt_q   <= 4'd0;
                flips_q <= 63'd0;
                state_q <= ST_DONE;
              end else begin
                for (int k = 0; k < LocLen; k++) begin
                  c_q[k] <= (k == 0) ? 6'd1 : 6'd0;
                  b_q[k] <= (k == 0) ? 6'd1 : 6'd0;
                end
                len_q   <= 5'd0;
                m_q     <= 5'd1;
                bd_q    <= 6'd1;
                n_q     <= 5'd0;
                i_q     <= 5'd1;
                d_q     <= syn_q[1];
                state_q <= ST_BM_D;
              end
            end else begin
              n_q <= n_q + 5'd1;
            end
          end else begin
            d_q <= mac_y;
            j_q <= j_q + 6'd1;
          end
        end
        ST_BM_D: begin
          if (i_q <= len_q && i_q <= n_q + 5'd1) begin
            d_q <= mac_y;
            i_q <= i_q + 5'd1;
          end else if (d_q == 6'd0) begin
            m_q     <= m_q + 5'd1;
            state_q <= ST_BM_NEXT;
          end else begin
            coef_q  <= gf_exp(mod63_add(gf_log(d_q), 6'd63 - gf_log(bd_q) == 6'd63 ?
                       6'd0 : 6'd63 - gf_log(bd_q)));
            grow_q  <= ({len_q, 1'b0} <= {1'b0, n_q});
            for (int k = 0; k < LocLen; k++) t_q[k] <= c_q[k];
            i_q     <= 5'd0;
            state_q <= ST_BM_UPD;
          end
        end
        ST_BM_UPD: begin
          if ({1'b0, i_q} + {1'b0, m_q} < 6'(LocLen)) begin
            c_q[i_q + m_q] <= mac_y;
            i_q            <= i_q + 5'd1;
          end else begin
            if (grow_q) begin
              len_q <= n_q + 5'd1 - len_q;
              for (int k = 0; k < LocLen; k++) b_q[k] <= t_q[k];
              bd_q  <= d_q;
              m_q   <= 5'd1;
            end else begin
              m_q <= m_q + 5'd1;
            end
            state_q <= ST_BM_NEXT;
          end
        end
        ST_BM_NEXT: begin
          if (n_q == 5'(NumSyn - 1)) begin
            if (len_q > 5'(TMax)) begin
              state_q <= ST_OUT;
              m_axis_tvalid <= 1'b1;
              m_axis_tdata  <= 24'd0;
            end else begin
              j_q     <= 6'd0;
              i_q     <= 5'd0;
              d_q     <= 6'd0;
              cnt_q   <= 4'd0;
              flips_q <= 63'd0;
              state_q <= ST_CH;
            end
          end else begin
            // next step starts from the syndrome after the one just used
            n_q     <= n_q + 5'd1;
            i_q     <= 5'd1;
            d_q     <= syn_q[n_q + 5'd2];
            state_q <= ST_BM_D;
          end
        end
        ST_CH: begin
          d_q <= mac_y;
          if (i_q == len_q) begin
            state_q <= ST_CH_NEXT;
          end else begin
            i_q <= i_q + 5'd1;
          end
        end
        ST_CH_NEXT: begin
          if (d_q == 6'd0) begin
            cnt_q         <= cnt_q + 4'd1;
            flips_q[pos]  <= 1'b1;
          end
          d_q <= 6'd0;
          i_q <= 5'd0;
          if (j_q == 6'd62) begin
            state_q <= ST_DONE;
          end else begin
            j_q     <= j_q + 6'd1;
            state_q <= ST_CH;
          end
        end
        ST_DONE: begin
          m_axis_tvalid <= 1'b1;
          state_q       <= ST_OUT;
          if ({1'b0, cnt_q} != len_q && nz_q) begin
            m_axis_tdata <= 24'd0;
          end else begin
            m_axis_tdata[0] <= 1'b1;
            m_axis_tdata[4:1] <= nz_q ? cnt_q : 4'd0;
            for (int k = 0; k < NacBits; k++)
              m_axis_tdata[16 - k] <= word_q[k] ^ flips_q[k];
            for (int k = 0; k < 4; k++)
              m_axis_tdata[20 - k] <= word_q[12 + k] ^ flips_q[12 + k];
            m_axis_tdata[23:21] <= 3'd0;
          end
        end
        ST_OUT: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
endmodule
`default_nettype wire
